@@ rtl/erwa_pkg.sv @@
package erwa_pkg;

   // field widths
   localparam int DIST_W  = 16;
   localparam int ECHO_W  = 16;
   localparam int SCALE_W = 12;
   localparam int PROD_W  = ECHO_W + SCALE_W;
   localparam int FRAC_SHIFT = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // default window length
   localparam int WINDOW_DEFAULT = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE_FACTOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ECHO_TIMEOUT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DISTANCE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OBST_DISTANCE = 2'd3;

   // register reset values
   localparam logic [SCALE_W-1:0] SCALE_RESET   = 12'd1124;
   localparam logic [ECHO_W-1:0]  TIMEOUT_RESET = 16'd10000;
   localparam logic [DIST_W-1:0]  MIN_RESET     = 16'd512;
   localparam logic [DIST_W-1:0]  OBST_RESET    = 16'd5120;

   // item codes
   localparam logic OP_MEASURE = 1'b0;
   localparam logic OP_CLEAR   = 1'b1;
   localparam logic SENSOR_LEFT  = 1'b0;
   localparam logic SENSOR_RIGHT = 1'b1;

   // sequencer to window store
   typedef struct packed {
      logic              clear;
      logic              insert;
      logic              sensor;
      logic [DIST_W-1:0] reading;
   } win_ctrl_type;

endpackage

@@ rtl/erwa_ifs.sv @@
// request channel
interface erwa_req_if;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic                       sensor;
   logic [erwa_pkg::ECHO_W-1:0] echo_us;

   modport source (output valid, output op, output sensor, output echo_us, input ready);
   modport sink (input valid, input op, input sensor, input echo_us, output ready);
endinterface

// response channel
interface erwa_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [erwa_pkg::DIST_W-1:0] measured_distance;
   logic                       measurement_valid;
   logic [erwa_pkg::DIST_W-1:0] left_average;
   logic                       left_valid;
   logic [erwa_pkg::DIST_W-1:0] right_average;
   logic                       right_valid;
   logic                       obstacle;
   logic                       any_valid;

   modport source (output valid, output measured_distance, output measurement_valid,
                   output left_average, output left_valid, output right_average,
                   output right_valid, output obstacle, output any_valid, input ready);
   modport sink (input valid, input measured_distance, input measurement_valid,
                 input left_average, input left_valid, input right_average,
                 input right_valid, input obstacle, input any_valid, output ready);
endinterface

@@ rtl/erwa_div.sv @@
// shared restoring divider, two quotient bits per cycle
module erwa_div #(
   parameter int SUM_W = 19,
   parameter int CNT_W = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output logic [SUM_W-1:0] quotient
);

   localparam int STEPS  = (SUM_W + 1) / 2;
   localparam int PAD_W  = 2 * STEPS;
   localparam int REM_W  = CNT_W + 1;
   localparam int ITER_W = $clog2(STEPS + 1);

   logic [PAD_W-1:0]  q_ff, q_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff;
   logic [ITER_W-1:0] iter_ff;
   logic              busy_ff, done_ff;

   // two shift and subtract steps
   always_comb begin
      logic [REM_W-1:0] r;
      logic [PAD_W-1:0] q;
      r = rem_ff;
      q = q_ff;
      for (int k = 0; k < 2; k++) begin
         r = {r[REM_W-2:0], q[PAD_W-1]};
         q = {q[PAD_W-2:0], 1'b0};
         if (r >= {1'b0, div_ff}) begin
            r    = r - {1'b0, div_ff};
            q[0] = 1'b1;
         end
      end
      rem_in = r;
      q_in   = q;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            iter_ff <= ITER_W'(STEPS);
         end else if (busy_ff) begin
            iter_ff <= iter_ff - 1'b1;
            if (iter_ff == ITER_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= PAD_W'(dividend);
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff[SUM_W-1:0];

endmodule

@@ rtl/erwa_win.sv @@
// two reading windows with fill counts and running sums
module erwa_win #(
   parameter int WINDOW = erwa_pkg::WINDOW_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  erwa_pkg::win_ctrl_type       ctrl,
   output logic [$clog2(WINDOW+1)-1:0]  count [2],
   output logic [erwa_pkg::DIST_W+$clog2(WINDOW)-1:0] sum [2]
);

   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W = erwa_pkg::DIST_W + $clog2(WINDOW);
   localparam int DW    = erwa_pkg::DIST_W;

   logic [DW-1:0]    win_ff    [2][WINDOW];
   logic [CNT_W-1:0] count_ff  [2];
   logic [POS_W-1:0] oldest_ff [2];
   logic [SUM_W-1:0] sum_ff    [2];

   logic             full;
   logic [CNT_W:0]   pos_wide;
   logic [POS_W-1:0] wpos;
   logic [POS_W-1:0] oldest_next;
   logic [DW-1:0]    old_val;
   logic [SUM_W-1:0] sum_in;

   // write position and sum update of the addressed window
   always_comb begin
      full     = (count_ff[ctrl.sensor] == CNT_W'(WINDOW));
      pos_wide = (CNT_W+1)'(oldest_ff[ctrl.sensor]) + (CNT_W+1)'(count_ff[ctrl.sensor]);
      if (pos_wide >= (CNT_W+1)'(WINDOW)) begin
         pos_wide = pos_wide - (CNT_W+1)'(WINDOW);
      end
      wpos    = full ? oldest_ff[ctrl.sensor] : pos_wide[POS_W-1:0];
      old_val = win_ff[ctrl.sensor][oldest_ff[ctrl.sensor]];
      if (oldest_ff[ctrl.sensor] == POS_W'(WINDOW - 1)) begin
         oldest_next = '0;
      end else begin
         oldest_next = oldest_ff[ctrl.sensor] + 1'b1;
      end
      sum_in = sum_ff[ctrl.sensor] + SUM_W'(ctrl.reading) - (full ? SUM_W'(old_val) : '0);
   end

   // counts, pointers and sums
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         for (int s = 0; s < 2; s++) begin
            count_ff[s]  <= '0;
            oldest_ff[s] <= '0;
            sum_ff[s]    <= '0;
         end
      end else if (ctrl.insert) begin
         sum_ff[ctrl.sensor] <= sum_in;
         if (full) begin
            oldest_ff[ctrl.sensor] <= oldest_next;
         end else begin
            count_ff[ctrl.sensor] <= count_ff[ctrl.sensor] + 1'b1;
         end
      end
   end

   // reading store
   always_ff @(posedge clock) begin
      if (ctrl.insert && !ctrl.clear) begin
         win_ff[ctrl.sensor][wpos] <= ctrl.reading;
      end
   end

   assign count = count_ff;
   assign sum   = sum_ff;

endmodule

@@ rtl/echo_range_window_average_core.sv @@
// channel   dir  handshake          payload
// req_port  in   valid/ready        op, sensor, echo_us
// rsp_port  out  valid/ready        distance, averages, valid flags, obstacle
// csr_*     in   csr_we, no stall   csr_index, csr_wdata
//
// a transfer in passes the multiply, window insert, left divide, right divide and done states
// and then the output register; the next item is taken only once the sequencer is idle again
// the shared divider is run once per window at two bits a cycle
// req_port.ready is high only while the sequencer is idle
// a finished result waits in the output register; a new item may be taken meanwhile
// reset is synchronous and empties both windows and restores register defaults
module echo_range_window_average_core #(
   parameter int WINDOW = erwa_pkg::WINDOW_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   erwa_req_if.sink                          req_port,
   erwa_rsp_if.source                        rsp_port,
   input  logic                              csr_we,
   input  logic [erwa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [erwa_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SUM_W = erwa_pkg::DIST_W + $clog2(WINDOW);
   localparam int DW    = erwa_pkg::DIST_W;
   localparam int PW    = erwa_pkg::PROD_W;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MUL    = 3'd1;
   localparam logic [2:0] S_INS    = 3'd2;
   localparam logic [2:0] S_LSTART = 3'd3;
   localparam logic [2:0] S_LWAIT  = 3'd4;
   localparam logic [2:0] S_RWAIT  = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   logic [2:0] state_ff;

   // configuration registers
   logic [erwa_pkg::SCALE_W-1:0] scale_ff;
   logic [erwa_pkg::ECHO_W-1:0]  timeout_ff;
   logic [DW-1:0]                min_ff;
   logic [DW-1:0]                obst_ff;

   // item registers
   logic                        op_ff, sensor_ff;
   logic [erwa_pkg::ECHO_W-1:0] echo_ff;
   logic [PW-1:0]               prod_ff;
   logic                        noecho_ff;
   logic [DW-1:0]               dist_ff, dist_in;
   logic                        mvalid_ff, mvalid_in;
   logic [DW-1:0]               la_ff, ra_ff;

   // output register
   logic          rsp_valid_ff;
   logic [DW-1:0] rsp_dist_ff, rsp_la_ff, rsp_ra_ff;
   logic          rsp_mvalid_ff, rsp_lv_ff, rsp_rv_ff, rsp_obst_ff;

   erwa_pkg::win_ctrl_type win_ctrl;
   logic [CNT_W-1:0] count [2];
   logic [SUM_W-1:0] sum   [2];

   logic             div_start, div_done, sel_right;
   logic [SUM_W-1:0] div_q;
   logic             accept, out_free;
   logic             lv, rv;

   assign accept   = req_port.valid && req_port.ready;
   assign out_free = !rsp_valid_ff || rsp_port.ready;
   assign req_port.ready = (state_ff == S_IDLE);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff   <= erwa_pkg::SCALE_RESET;
         timeout_ff <= erwa_pkg::TIMEOUT_RESET;
         min_ff     <= erwa_pkg::MIN_RESET;
         obst_ff    <= erwa_pkg::OBST_RESET;
      end else if (csr_we) begin
         case (csr_index)
            erwa_pkg::CSR_SCALE_FACTOR:  scale_ff   <= csr_wdata[erwa_pkg::SCALE_W-1:0];
            erwa_pkg::CSR_ECHO_TIMEOUT:  timeout_ff <= csr_wdata;
            erwa_pkg::CSR_MIN_DISTANCE:  min_ff     <= csr_wdata;
            erwa_pkg::CSR_OBST_DISTANCE: obst_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // distance and window entry decision
   always_comb begin
      if (op_ff == erwa_pkg::OP_CLEAR || noecho_ff) begin
         dist_in = '0;
      end else if (prod_ff[PW-1:erwa_pkg::FRAC_SHIFT+DW] != '0) begin
         dist_in = '1;
      end else begin
         dist_in = prod_ff[erwa_pkg::FRAC_SHIFT +: DW];
      end
      mvalid_in = (op_ff == erwa_pkg::OP_MEASURE) && !noecho_ff && (dist_in > min_ff);
   end

   always_comb begin
      win_ctrl.clear   = (state_ff == S_INS) && (op_ff == erwa_pkg::OP_CLEAR);
      win_ctrl.insert  = (state_ff == S_INS) && mvalid_in;
      win_ctrl.sensor  = sensor_ff;
      win_ctrl.reading = dist_in;
   end

   erwa_win #(.WINDOW(WINDOW)) u_win (
      .clock (clock),
      .reset (reset),
      .ctrl  (win_ctrl),
      .count (count),
      .sum   (sum)
   );

   // divider runs left window first, then right
   assign sel_right = (state_ff == S_LWAIT);
   assign div_start = (state_ff == S_LSTART) || ((state_ff == S_LWAIT) && div_done);

   erwa_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sel_right ? sum[1] : sum[0]),
      .divisor  (sel_right ? count[1] : count[0]),
      .done     (div_done),
      .quotient (div_q)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE:   if (accept) state_ff <= S_MUL;
            S_MUL:    state_ff <= S_INS;
            S_INS:    state_ff <= S_LSTART;
            S_LSTART: state_ff <= S_LWAIT;
            S_LWAIT:  if (div_done) state_ff <= S_RWAIT;
            S_RWAIT:  if (div_done) state_ff <= S_DONE;
            S_DONE:   if (out_free) state_ff <= S_IDLE;
            default:  state_ff <= S_IDLE;
         endcase
      end
   end

   // item datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_port.op;
         sensor_ff <= req_port.sensor;
         echo_ff   <= req_port.echo_us;
      end
      if (state_ff == S_MUL) begin
         prod_ff   <= PW'(echo_ff) * PW'(scale_ff);
         noecho_ff <= (echo_ff == '0) || (echo_ff > timeout_ff);
      end
      if (state_ff == S_INS) begin
         dist_ff   <= dist_in;
         mvalid_ff <= mvalid_in;
      end
      if (state_ff == S_LWAIT && div_done) begin
         la_ff <= (count[0] == '0) ? '0 : div_q[DW-1:0];
      end
      if (state_ff == S_RWAIT && div_done) begin
         ra_ff <= (count[1] == '0) ? '0 : div_q[DW-1:0];
      end
   end

   assign lv = (la_ff > min_ff);
   assign rv = (ra_ff > min_ff);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && out_free) begin
         rsp_dist_ff   <= dist_ff;
         rsp_mvalid_ff <= mvalid_ff;
         rsp_la_ff     <= la_ff;
         rsp_ra_ff     <= ra_ff;
         rsp_lv_ff     <= lv;
         rsp_rv_ff     <= rv;
         rsp_obst_ff   <= (count[0] == '0) || (count[1] == '0) ||
                          (la_ff < obst_ff) || (ra_ff < obst_ff);
      end
   end

   assign rsp_port.valid             = rsp_valid_ff;
   assign rsp_port.measured_distance = rsp_dist_ff;
   assign rsp_port.measurement_valid = rsp_mvalid_ff;
   assign rsp_port.left_average      = rsp_la_ff;
   assign rsp_port.left_valid        = rsp_lv_ff;
   assign rsp_port.right_average     = rsp_ra_ff;
   assign rsp_port.right_valid       = rsp_rv_ff;
   assign rsp_port.obstacle          = rsp_obst_ff;
   assign rsp_port.any_valid         = rsp_lv_ff || rsp_rv_ff;

`ifndef SYNTH
   // fill counts stay within the window
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count[0] <= CNT_W'(WINDOW)) && (count[1] <= CNT_W'(WINDOW)))
      else $error("window fill count beyond window length");

   // an empty window carries no sum
   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      ((count[0] != '0) || (sum[0] == '0)) && ((count[1] != '0) || (sum[1] == '0)))
      else $error("empty window with nonzero sum");

   // divider finishes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_LWAIT || state_ff == S_RWAIT))
      else $error("divider result outside a wait state");

   // a transfer in starts the multiply step
   a_accept_mul: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_MUL))
      else $error("accepted item did not start");
`endif

endmodule

@@ test/tb.sv @@
module tb;

   localparam int HALF_PERIOD  = 5;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int WINDOW       = erwa_pkg::WINDOW_DEFAULT;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 72;
   localparam int SETTLE       = 40;

   // one result transfer, in port order
   typedef struct packed {
      logic [erwa_pkg::DIST_W-1:0] measured_distance;
      logic                        measurement_valid;
      logic [erwa_pkg::DIST_W-1:0] left_average;
      logic                        left_valid;
      logic [erwa_pkg::DIST_W-1:0] right_average;
      logic                        right_valid;
      logic                        obstacle;
      logic                        any_valid;
   } range_report_type;

   // one line of the directed sequence: a register write or an item
   typedef struct {
      bit                              is_csr;
      logic [erwa_pkg::CSR_IDX_W-1:0]  csr_idx;
      logic [erwa_pkg::CSR_DATA_W-1:0] csr_data;
      logic                            op;
      logic                            sensor;
      logic [erwa_pkg::ECHO_W-1:0]     echo;
      bit                              typed;
      range_report_type                want;
   } stim_row_type;

   // both windows empty, nothing measured
   localparam range_report_type EMPTY_REPORT =
      '{16'd0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0, 1'b1, 1'b0};

   logic clock;
   logic reset;
   logic csr_we;
   logic [erwa_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [erwa_pkg::CSR_DATA_W-1:0] csr_wdata;

   erwa_req_if req_bus ();
   erwa_rsp_if rsp_bus ();

   echo_range_window_average_core #(.WINDOW(WINDOW)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_bus),
      .rsp_port  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the register file and of both windows
   logic [erwa_pkg::SCALE_W-1:0] cfg_scale;
   logic [erwa_pkg::ECHO_W-1:0]  cfg_timeout;
   logic [erwa_pkg::DIST_W-1:0]  cfg_min;
   logic [erwa_pkg::DIST_W-1:0]  cfg_obst;
   logic [erwa_pkg::DIST_W-1:0]  win_store [2][WINDOW];
   int unsigned                  win_fill [2];
   int unsigned                  win_head [2];
   int unsigned                  win_total [2];

   range_report_type awaited [$];
   int               mismatches = 0;
   int unsigned      cycle_count = 0;
   bit               req_calm = 0;
   bit               rsp_calm = 0;

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // apply one item to the shadow windows and work out its report
   function automatic range_report_type advance_windows(logic op, logic sensor,
                                                        logic [erwa_pkg::ECHO_W-1:0] echo);
      range_report_type r;
      int unsigned      product;
      int unsigned      reading;
      int unsigned      slot;
      int unsigned      avg [2];
      r = '0;
      reading = 0;
      if (op == erwa_pkg::OP_CLEAR) begin
         for (int s = 0; s < 2; s++) begin
            win_fill[s]  = 0;
            win_head[s]  = 0;
            win_total[s] = 0;
         end
      end else if (echo != 0 && echo <= cfg_timeout) begin
         product = (32'(echo) * 32'(cfg_scale)) >> erwa_pkg::FRAC_SHIFT;
         reading = (product > 32'hFFFF) ? 32'hFFFF : product;
         if (reading > cfg_min) begin
            // append while filling, then overwrite the oldest
            if (win_fill[sensor] < WINDOW) begin
               slot = (win_head[sensor] + win_fill[sensor]) % WINDOW;
               win_fill[sensor]++;
            end else begin
               slot = win_head[sensor];
               win_total[sensor] -= win_store[sensor][slot];
               win_head[sensor] = (slot + 1) % WINDOW;
            end
            win_store[sensor][slot] = reading[erwa_pkg::DIST_W-1:0];
            win_total[sensor] += reading;
            r.measurement_valid = 1'b1;
         end
      end
      for (int s = 0; s < 2; s++)
         avg[s] = (win_fill[s] == 0) ? 0 : win_total[s] / win_fill[s];
      r.measured_distance = reading[erwa_pkg::DIST_W-1:0];
      r.left_average  = avg[0][erwa_pkg::DIST_W-1:0];
      r.right_average = avg[1][erwa_pkg::DIST_W-1:0];
      r.left_valid    = avg[0] > cfg_min;
      r.right_valid   = avg[1] > cfg_min;
      r.obstacle      = win_fill[0] == 0 || win_fill[1] == 0 ||
                        avg[0] < cfg_obst || avg[1] < cfg_obst;
      r.any_valid     = r.left_valid | r.right_valid;
      return r;
   endfunction

   function automatic stim_row_type item_row(logic op, logic sensor,
                                             logic [erwa_pkg::ECHO_W-1:0] echo);
      stim_row_type row;
      row = '{default: '0};
      row.op = op;
      row.sensor = sensor;
      row.echo = echo;
      return row;
   endfunction

   function automatic stim_row_type known_row(logic op, logic sensor,
                                              logic [erwa_pkg::ECHO_W-1:0] echo,
                                              range_report_type want);
      stim_row_type row;
      row = item_row(op, sensor, echo);
      row.typed = 1'b1;
      row.want = want;
      return row;
   endfunction

   function automatic stim_row_type csr_row(logic [erwa_pkg::CSR_IDX_W-1:0] idx,
                                            logic [erwa_pkg::CSR_DATA_W-1:0] data);
      stim_row_type row;
      row = '{default: '0};
      row.is_csr = 1'b1;
      row.csr_idx = idx;
      row.csr_data = data;
      return row;
   endfunction

   // hold the sender back until every report has come out
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (awaited.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // register write, only once the block is idle
   task automatic write_register(logic [erwa_pkg::CSR_IDX_W-1:0] idx,
                                 logic [erwa_pkg::CSR_DATA_W-1:0] data);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (idx)
         erwa_pkg::CSR_SCALE_FACTOR:  cfg_scale   = data[erwa_pkg::SCALE_W-1:0];
         erwa_pkg::CSR_ECHO_TIMEOUT:  cfg_timeout = data;
         erwa_pkg::CSR_MIN_DISTANCE:  cfg_min     = data;
         erwa_pkg::CSR_OBST_DISTANCE: cfg_obst    = data;
         default: ;
      endcase
   endtask

   // one request transfer; starts and ends at a falling edge
   task automatic send_item(logic op, logic sensor, logic [erwa_pkg::ECHO_W-1:0] echo,
                            bit typed, range_report_type typed_report);
      int               gap;
      range_report_type forecast;
      gap = req_calm ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.op      <= op;
      req_bus.sensor  <= sensor;
      req_bus.echo_us <= echo;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      forecast = advance_windows(op, sensor, echo);
      awaited = {awaited, (typed ? typed_report : forecast)};
      @(negedge clock);
   endtask

   // result side: random stalls, each transfer checked against the oldest forecast
   initial begin : result_monitor
      range_report_type seen;
      range_report_type want;
      int               stall;
      int               served;
      rsp_bus.ready = 1'b0;
      served = 0;
      @(negedge reset);
      forever begin
         if (served % 16 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
         stall = rsp_calm ? 0 : $urandom_range(0, 6);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         seen = '{rsp_bus.measured_distance, rsp_bus.measurement_valid,
                  rsp_bus.left_average, rsp_bus.left_valid,
                  rsp_bus.right_average, rsp_bus.right_valid,
                  rsp_bus.obstacle, rsp_bus.any_valid};
         if (awaited.size() == 0) begin
            $error("result transfer with no item outstanding");
            mismatches++;
         end else begin
            want = awaited.pop_front();
            if (seen.measured_distance !== want.measured_distance) begin
               $error("measured_distance: expected %0d, actual %0d",
                      want.measured_distance, seen.measured_distance);
               mismatches++;
            end
            if (seen.measurement_valid !== want.measurement_valid) begin
               $error("measurement_valid: expected %0d, actual %0d",
                      want.measurement_valid, seen.measurement_valid);
               mismatches++;
            end
            if (seen.left_average !== want.left_average) begin
               $error("left_average: expected %0d, actual %0d",
                      want.left_average, seen.left_average);
               mismatches++;
            end
            if (seen.left_valid !== want.left_valid) begin
               $error("left_valid: expected %0d, actual %0d",
                      want.left_valid, seen.left_valid);
               mismatches++;
            end
            if (seen.right_average !== want.right_average) begin
               $error("right_average: expected %0d, actual %0d",
                      want.right_average, seen.right_average);
               mismatches++;
            end
            if (seen.right_valid !== want.right_valid) begin
               $error("right_valid: expected %0d, actual %0d",
                      want.right_valid, seen.right_valid);
               mismatches++;
            end
            if (seen.obstacle !== want.obstacle) begin
               $error("obstacle: expected %0d, actual %0d",
                      want.obstacle, seen.obstacle);
               mismatches++;
            end
            if (seen.any_valid !== want.any_valid) begin
               $error("any_valid: expected %0d, actual %0d",
                      want.any_valid, seen.any_valid);
               mismatches++;
            end
         end
         served++;
         @(negedge clock);
      end
   end

   // stimulus
   initial begin : stimulus
      stim_row_type                    directed [$];
      logic [erwa_pkg::CSR_DATA_W-1:0] settings [4];
      logic                            op;
      logic                            sensor;
      logic [erwa_pkg::ECHO_W-1:0]     echo;
      int                              pick;

      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_bus.valid   = 1'b0;
      req_bus.op      = erwa_pkg::OP_MEASURE;
      req_bus.sensor  = erwa_pkg::SENSOR_LEFT;
      req_bus.echo_us = '0;

      // shadow state after reset
      cfg_scale   = erwa_pkg::SCALE_RESET;
      cfg_timeout = erwa_pkg::TIMEOUT_RESET;
      cfg_min     = erwa_pkg::MIN_RESET;
      cfg_obst    = erwa_pkg::OBST_RESET;
      for (int s = 0; s < 2; s++) begin
         win_fill[s]  = 0;
         win_head[s]  = 0;
         win_total[s] = 0;
      end

      // default registers: no echo, over the timeout, clear, edge of the timeout
      directed = {directed,
         known_row(erwa_pkg::OP_MEASURE, erwa_pkg::SENSOR_LEFT, 16'd0, EMPTY_REPORT),
         known_row(erwa_pkg::OP_MEASURE, erwa_pkg::SENSOR_RIGHT, 16'hFFFF, EMPTY_REPORT),
         known_row(erwa_pkg::OP_CLEAR, erwa_pkg::SENSOR_RIGHT, 16'hFFFF, EMPTY_REPORT),
         item_row(erwa_pkg::OP_MEASURE, erwa_pkg::SENSOR_LEFT, 16'd10000),
         item_row(erwa_pkg::OP_MEASURE, erwa_pkg::SENSOR_LEFT, 16'd10001)};
      // short readings either side of the minimum distance
      directed = {directed,
         item_row(erwa_pkg::OP_MEASURE, erwa_pkg::SENSOR_RIGHT, 16'd1),
         item_row(erwa_pkg::OP_MEASURE, erwa_pkg::SENSOR_RIGHT, 16'd116),
         item_row(erwa_pkg::OP_MEASURE, erwa_pkg::SENSOR_RIGHT, 16'd117)};
      // fill the left window and wrap it twice
      directed = {directed,
         item_row(erwa_pkg::OP_MEASURE, erwa_pkg::SENSOR_LEFT, 16'd200),
         item_row(erwa_pkg::OP_MEASURE, erwa_pkg::SENSOR_LEFT, 16'd300),
         item_row(erwa_pkg::OP_MEASURE, erwa_pkg::SENSOR_LEFT, 16'd400),
         item_row(erwa_pkg::OP_MEASURE, erwa_pkg::SENSOR_LEFT, 16'd500),
         item_row(erwa_pkg::OP_MEASURE, erwa_pkg::SENSOR_LEFT, 16'd600),
         item_row(erwa_pkg::OP_MEASURE, erwa_pkg::SENSOR_LEFT, 16'd700),
         known_row(erwa_pkg::OP_CLEAR, erwa_pkg::SENSOR_LEFT, 16'd0, EMPTY_REPORT)};
      // saturation, zero thresholds: an empty window still flags an obstacle
      directed = {directed,
         csr_row(erwa_pkg::CSR_SCALE_FACTOR, 16'd4095),
         csr_row(erwa_pkg::CSR_ECHO_TIMEOUT, 16'hFFFF),
         csr_row(erwa_pkg::CSR_MIN_DISTANCE, 16'd0),
         csr_row(erwa_pkg::CSR_OBST_DISTANCE, 16'd0),
         known_row(erwa_pkg::OP_MEASURE, erwa_pkg::SENSOR_RIGHT, 16'hFFFF,
            '{16'hFFFF, 1'b1, 16'd0, 1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b1}),
         item_row(erwa_pkg::OP_MEASURE, erwa_pkg::SENSOR_LEFT, 16'd1),
         item_row(erwa_pkg::OP_MEASURE, erwa_pkg::SENSOR_LEFT, 16'hFFFF)};
      // top thresholds: a saturated reading is still too short
      directed = {directed,
         csr_row(erwa_pkg::CSR_MIN_DISTANCE, 16'hFFFF),
         csr_row(erwa_pkg::CSR_OBST_DISTANCE, 16'hFFFF),
         item_row(erwa_pkg::OP_MEASURE, erwa_pkg::SENSOR_LEFT, 16'hFFFF)};
      // timeout register zero: every width is treated as no echo
      directed = {directed,
         csr_row(erwa_pkg::CSR_ECHO_TIMEOUT, 16'd0),
         item_row(erwa_pkg::OP_MEASURE, erwa_pkg::SENSOR_LEFT, 16'd1),
         item_row(erwa_pkg::OP_MEASURE, erwa_pkg::SENSOR_RIGHT, 16'hFFFF)};
      // zero scale: distance zero, never above the minimum
      directed = {directed,
         csr_row(erwa_pkg::CSR_SCALE_FACTOR, 16'd0),
         csr_row(erwa_pkg::CSR_ECHO_TIMEOUT, 16'hFFFF),
         csr_row(erwa_pkg::CSR_MIN_DISTANCE, 16'd0),
         item_row(erwa_pkg::OP_MEASURE, erwa_pkg::SENSOR_RIGHT, 16'd40000)};

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) begin
         if (directed[i].is_csr)
            write_register(directed[i].csr_idx, directed[i].csr_data);
         else
            send_item(directed[i].op, directed[i].sensor, directed[i].echo,
                      directed[i].typed, directed[i].want);
      end

      // random phases, each under its own register setting
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: settings = '{16'd1124, 16'd10000, 16'd512, 16'd5120};
            1: settings = '{16'd4095, 16'hFFFF, 16'd0, 16'hFFFF};
            2: settings = '{16'd4095, 16'hFFFF, 16'hFFFF, 16'd0};
            3: settings = '{16'd4095, 16'd1, 16'd0, 16'd16};
            4: settings = '{16'd1, 16'hFFFF, 16'd0, 16'd128};
            default: settings = '{16'($urandom_range(0, 4095)),
                                  16'($urandom_range(1, 65535)),
                                  16'($urandom_range(0, 4096)),
                                  16'($urandom_range(0, 65535))};
         endcase
         write_register(erwa_pkg::CSR_SCALE_FACTOR, settings[0]);
         write_register(erwa_pkg::CSR_ECHO_TIMEOUT, settings[1]);
         write_register(erwa_pkg::CSR_MIN_DISTANCE, settings[2]);
         write_register(erwa_pkg::CSR_OBST_DISTANCE, settings[3]);

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 16 == 0) req_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 39) == 0) drain_results();
            // mostly accepted widths, with clears, no-echo and raw noise mixed in
            pick   = $urandom_range(0, 99);
            op     = (pick < 4) ? erwa_pkg::OP_CLEAR : erwa_pkg::OP_MEASURE;
            sensor = 1'($urandom_range(0, 1));
            if (pick < 10)
               echo = 16'($urandom);
            else if (pick < 15)
               echo = '0;
            else if (pick < 20 && cfg_timeout != 16'hFFFF)
               echo = 16'($urandom_range(cfg_timeout + 1, 65535));
            else if (cfg_timeout == 0)
               echo = 16'($urandom);
            else
               echo = 16'($urandom_range(1, cfg_timeout));
            send_item(op, sensor, echo, 1'b0, '0);
         end
      end

      req_bus.valid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/erwa_pkg.sv
rtl/erwa_ifs.sv
rtl/erwa_div.sv
rtl/erwa_win.sv
rtl/echo_range_window_average_core.sv
test/tb.sv
